// ----- hdl/swtq_pkg.sv -----
// Shared types, constants and control structs of the sorted wake-up timer queue.
package swtq_pkg;

    // Fixed field widths and default queue depth
    localparam int TIME_BITS         = 48;
    localparam int ID_BITS           = 8;
    localparam int QUEUE_DEPTH_DEF   = 16;

    localparam logic [TIME_BITS-1:0] TIME_NONE = '1;

    // Operation codes
    localparam logic OP_SLEEP = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_WOKEN       = 2'd0,
        ST_QUEUED      = 2'd1,
        ST_ALREADY_DUE = 2'd2,
        ST_FULL        = 2'd3
    } t_status;

    typedef struct packed {
        logic                 operation;
        logic [ID_BITS-1:0]   requester_id;
        logic [TIME_BITS-1:0] wake_time;
        logic [TIME_BITS-1:0] tick_now;
    } t_in_item;

    typedef struct packed {
        logic [ID_BITS-1:0] released_id;
        t_status            result_status;
        logic               last_of_run;
    } t_out_item;

    // One queue slot
    typedef struct packed {
        logic [TIME_BITS-1:0] wake_time;
        logic [ID_BITS-1:0]   id;
    } t_entry;

    // Controller to datapath
    typedef struct packed {
        logic    load;
        logic    rd_ins;
        logic    shift;
        logic    put_new;
        logic    pop;
        logic    set_earl_rd;
        logic    set_earl_none;
        logic    emit;
        logic    emit_cand;
        logic    emit_last;
        t_status emit_status;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_tick;
        logic is_due;
        logic is_full;
        logic is_empty;
        logic tick_due;
        logic idx_zero;
        logic idx_one;
        logic rd_gt;
        logic rd_match;
        logic occ_one;
        logic have_cand;
    } t_stat;

endpackage

// ----- hdl/swtq_datapath.sv -----
// Datapath: entry memory, head pointer, occupancy, earliest time and result register.
module swtq_datapath #(
    parameter int QUEUE_DEPTH = swtq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  swtq_pkg::t_in_item  i_item,
    input  swtq_pkg::t_cmd      i_cmd,
    output swtq_pkg::t_stat     o_stat,
    output logic                o_strobe,
    output swtq_pkg::t_out_item o_result
);
    import swtq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int IW = $clog2(QUEUE_DEPTH + 1);

    t_entry               r_mem [QUEUE_DEPTH];
    t_entry               r_rd;
    t_in_item             r_item;
    logic [IW-1:0]        r_idx,      n_idx;
    logic [IW-1:0]        r_occ,      n_occ;
    logic [AW-1:0]        r_hd,       n_hd;
    logic [TIME_BITS-1:0] r_earliest, n_earliest;
    logic [ID_BITS-1:0]   r_cand;
    logic                 r_have,     n_have;
    logic                 r_strobe;
    t_out_item            r_result;

    logic [IW-1:0]        w_lrd;
    logic [AW-1:0]        w_raddr;
    logic [AW-1:0]        w_waddr;
    logic                 w_we;
    t_entry               w_wdata;

    // Map a queue position to a memory slot, wrapping once past the end
    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] hd,
                                             input logic [IW-1:0] lidx);
        logic [IW:0] sum;
        sum = (IW+1)'(hd) + (IW+1)'(lidx);
        if (sum >= (IW+1)'(QUEUE_DEPTH)) begin
            sum = sum - (IW+1)'(QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    // Select the read position for the next cycle
    always_comb begin
        if (i_cmd.pop) begin
            w_lrd = IW'(1);
        end else if (i_cmd.shift) begin
            w_lrd = (r_idx > IW'(1)) ? r_idx - IW'(2) : '0;
        end else if (i_cmd.rd_ins) begin
            w_lrd = r_idx - IW'(1);
        end else begin
            w_lrd = '0;
        end
        w_raddr = f_phys(r_hd, w_lrd);
    end

    // Write either a shifted entry or the new one at the insert position
    always_comb begin
        w_waddr = f_phys(r_hd, r_idx);
        w_we    = i_cmd.shift | i_cmd.put_new;
        if (i_cmd.shift) begin
            w_wdata = r_rd;
        end else begin
            w_wdata.wake_time = r_item.wake_time;
            w_wdata.id        = r_item.requester_id;
        end
    end

    // Entry memory with registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd <= r_mem[w_raddr];
    end

    // Next values of the queue bookkeeping
    always_comb begin
        n_idx      = r_idx;
        n_occ      = r_occ;
        n_hd       = r_hd;
        n_earliest = r_earliest;
        n_have     = r_have;
        if (i_cmd.load) begin
            n_idx  = r_occ;
            n_have = 1'b0;
        end
        if (i_cmd.shift) begin
            n_idx = r_idx - IW'(1);
        end
        if (i_cmd.put_new) begin
            n_occ = r_occ + IW'(1);
            if (r_idx == '0) begin
                n_earliest = r_item.wake_time;
            end
        end
        if (i_cmd.pop) begin
            n_have = 1'b1;
            n_occ  = r_occ - IW'(1);
            n_hd   = (r_hd == AW'(QUEUE_DEPTH - 1)) ? '0 : r_hd + AW'(1);
        end
        if (i_cmd.set_earl_rd) begin
            n_earliest = r_rd.wake_time;
        end
        if (i_cmd.set_earl_none) begin
            n_earliest = TIME_NONE;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ      <= '0;
            r_hd       <= '0;
            r_earliest <= TIME_NONE;
            r_have     <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_occ      <= n_occ;
            r_hd       <= n_hd;
            r_earliest <= n_earliest;
            r_have     <= n_have;
            r_strobe   <= i_cmd.emit;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.pop) begin
            r_cand <= r_rd.id;
        end
        if (i_cmd.emit) begin
            r_result.released_id   <= i_cmd.emit_cand ? r_cand : r_item.requester_id;
            r_result.result_status <= i_cmd.emit_status;
            r_result.last_of_run   <= i_cmd.emit_last;
        end
    end

    // Status to the controller
    always_comb begin
        o_stat.is_tick   = (r_item.operation == OP_TICK);
        o_stat.is_due    = (r_item.tick_now >= r_item.wake_time);
        o_stat.is_full   = (r_occ >= IW'(QUEUE_DEPTH));
        o_stat.is_empty  = (r_occ == '0);
        o_stat.tick_due  = (r_item.tick_now >= r_earliest);
        o_stat.idx_zero  = (r_idx == '0);
        o_stat.idx_one   = (r_idx == IW'(1));
        o_stat.rd_gt     = (r_rd.wake_time > r_item.wake_time);
        o_stat.rd_match  = (r_rd.wake_time == r_earliest);
        o_stat.occ_one   = (r_occ == IW'(1));
        o_stat.have_cand = r_have;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ----- hdl/swtq_ctrl.sv -----
// Controller: sequences sorted insertion and group release over the datapath.
module swtq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  swtq_pkg::t_stat i_stat,
    output swtq_pkg::t_cmd  o_cmd,
    output logic            busy
);
    import swtq_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_DECIDE   = 6'b000010,
        S_INS_CMP  = 6'b000100,
        S_INS_PUT  = 6'b001000,
        S_REL      = 6'b010000,
        S_REL_LAST = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (!i_stat.is_tick) begin
                    if (i_stat.is_due) begin
                        o_cmd.emit        = 1'b1;
                        o_cmd.emit_last   = 1'b1;
                        o_cmd.emit_status = ST_ALREADY_DUE;
                        n_state           = S_IDLE;
                    end else if (i_stat.is_full) begin
                        o_cmd.emit        = 1'b1;
                        o_cmd.emit_last   = 1'b1;
                        o_cmd.emit_status = ST_FULL;
                        n_state           = S_IDLE;
                    end else if (i_stat.idx_zero) begin
                        o_cmd.put_new     = 1'b1;
                        o_cmd.emit        = 1'b1;
                        o_cmd.emit_last   = 1'b1;
                        o_cmd.emit_status = ST_QUEUED;
                        n_state           = S_IDLE;
                    end else begin
                        o_cmd.rd_ins = 1'b1;
                        n_state      = S_INS_CMP;
                    end
                end else if (i_stat.is_empty || !i_stat.tick_due) begin
                    n_state = S_IDLE;
                end else begin
                    // head entry is read this cycle
                    n_state = S_REL;
                end
            end
            S_INS_CMP: begin
                if (i_stat.rd_gt) begin
                    o_cmd.shift = 1'b1;
                    n_state     = i_stat.idx_one ? S_INS_PUT : S_INS_CMP;
                end else begin
                    o_cmd.put_new     = 1'b1;
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_last   = 1'b1;
                    o_cmd.emit_status = ST_QUEUED;
                    n_state           = S_IDLE;
                end
            end
            S_INS_PUT: begin
                o_cmd.put_new     = 1'b1;
                o_cmd.emit        = 1'b1;
                o_cmd.emit_last   = 1'b1;
                o_cmd.emit_status = ST_QUEUED;
                n_state           = S_IDLE;
            end
            S_REL: begin
                o_cmd.emit_cand   = 1'b1;
                o_cmd.emit_status = ST_WOKEN;
                if (i_stat.rd_match) begin
                    // drop the head; the previous candidate is not the last
                    o_cmd.pop  = 1'b1;
                    o_cmd.emit = i_stat.have_cand;
                    n_state    = i_stat.occ_one ? S_REL_LAST : S_REL;
                end else begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_last   = 1'b1;
                    o_cmd.set_earl_rd = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_REL_LAST: begin
                o_cmd.emit          = 1'b1;
                o_cmd.emit_cand     = 1'b1;
                o_cmd.emit_last     = 1'b1;
                o_cmd.emit_status   = ST_WOKEN;
                o_cmd.set_earl_none = 1'b1;
                n_state             = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

// ----- hdl/sorted_wakeup_timer_queue_top.sv -----
// Sorted wake-up timer queue: top level joining controller and datapath.
//
// Usage: drive i_item and raise start while busy is low; the item transfers
// at that clock edge. operation OP_SLEEP queues requester_id at wake_time in
// time order (equal times keep arrival order) and answers with one result:
// queued, already due (tick_now >= wake_time) or rejected when full.
// operation OP_TICK releases every entry holding the earliest wake time once
// tick_now reaches it, one result per cycle, last_of_run on the final one;
// a tick with nothing due gives no result.
// Each result shows on o_result for one cycle with o_strobe high; there is no
// backpressure, so the receiver must take it then.
// Timing: an immediate answer, an insert into an empty queue and an idle
// tick end straight after the decision; an insert into a non-empty queue
// first moves each later entry up one slot, and a tick walks over every
// entry it releases. The walk over the entry memory reads one entry per
// cycle and, when inserting, writes one. The last result of an item
// is taken at the edge where the next transfer can happen; wake results come
// one per cycle.
// Reset (synchronous, i_rst_n low) empties the queue and clears the earliest
// time to all ones; no clearing pass is needed, the entry memory is never used
// past occupancy.
module sorted_wakeup_timer_queue_top #(
    parameter int QUEUE_DEPTH = swtq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  swtq_pkg::t_in_item  i_item,
    output logic                busy,
    output logic                o_strobe,
    output swtq_pkg::t_out_item o_result
);
    import swtq_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    swtq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .busy    (busy)
    );

    swtq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // Only a wake result can be followed by another result of the same item
    a_last_on_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_result.result_status != ST_WOKEN) |-> o_result.last_of_run)
        else $error("non-wake result without last_of_run");

    // A transfer keeps the block busy for the following cycle
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("block not busy after transfer");

    // Never insert into a full queue
    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.put_new |-> !w_stat.is_full)
        else $error("insert into full queue");

    // Never release from an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.pop |-> !w_stat.is_empty)
        else $error("release from empty queue");

endmodule
